/* rtl/assert_macros.svh */
// Assertion macros for the frame replacement block.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define LFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle that forces a condition in the next.
`define LFR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

/* rtl/lfr_pkg.sv */
// Shared types and codes for the LFU frame replacement block.
// No dependencies.
package lfr_pkg;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_ACCESS  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  localparam logic [1:0] MD_ALLOC_FREE  = 2'd0;
  localparam logic [1:0] MD_ALLOC_EVICT = 2'd1;
  localparam logic [1:0] MD_ACCESS      = 2'd2;
  localparam logic [1:0] MD_RELEASE     = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] frame;
    logic [7:0] process_id;
    logic [3:0] virtual_slot;
  } in_word_t;

  typedef struct packed {
    logic [3:0] result_frame;
    logic       status;
    logic       evicted;
    logic [7:0] owner_process_out;
    logic [3:0] owner_slot_out;
    logic [7:0] use_count_out;
  } out_word_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       is_tgt;
    logic       ent_valid;
  } alu_ctl_t;

endpackage

/* rtl/lfr_in_if.sv */
// Request channel: valid/ready handshake carrying one request word.
// Depends on lfr_pkg.
interface lfr_in_if import lfr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/lfr_out_if.sv */
// Result channel: valid/ready handshake carrying one result word.
// Depends on lfr_pkg.
interface lfr_out_if import lfr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/lfu_frame_replacement_top.sv */
// LFU frame table: allocate, access and release requests end in one read-modify-write sweep.
// Entry RAM (count, recency rank, owner tags) holds state; valid bits are flops.
//
// Usage:
//   in_s  : request words {operation, frame, process_id, virtual_slot}.
//   out_s : one result word per request, held in an output register.
//   in_s.ready is high only while the sequencer is idle; one request at a time.
//   Steps below run from the accepted request to the result word on out_s.
//   Allocate : one scan over all frames (lowest free frame, else least count
//              and oldest rank), then one update sweep.
//   Access / release : read the target entry, then one update sweep over the ranks.
//   Query : read the target entry only. Non-resident frame: no RAM read.
//   The next request can be taken in the same cycle the result word is presented.
//   Scan and update sweeps go through the single RAM read port, one frame per cycle.
//   Reset (synchronous, rst_n low) clears all valid bits: every frame is free.
//   A stalled out_s keeps its word; the next result waits in the sequencer
//   until the output register is free, and no new request is taken meanwhile.
`include "assert_macros.svh"
module lfu_frame_replacement_top import lfr_pkg::*; #(
  parameter int FRAMES     = 16,
  parameter int VSLOTS     = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  lfr_in_if.sink    in_s,
  lfr_out_if.source out_s
);

  localparam int FW = $clog2(FRAMES);
  localparam int RW = FW;
  localparam int CB = COUNT_BITS;
  localparam int WW = CB + RW + 12;
  localparam int XW = (FW > 4) ? FW : 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_PREPD = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  function automatic logic [3:0] slot_mod(input logic [3:0] s);
    logic [3:0] v;
    v = s;
    for (int k = 0; k < 8; k++) begin
      if ({5'b0, v} >= 9'(VSLOTS)) begin
        v = v - 4'(VSLOTS);
      end
    end
    return v;
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [FRAMES-1:0] valid_r, valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FW:0]       sc_r, sc_nxt;
  logic              pv_r, pv_nxt;
  logic [FW-1:0]     pidx_r, pidx_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [FW-1:0]     tgt_r, tgt_nxt;
  logic [7:0]        pid_r, pid_nxt;
  logic [3:0]        slot_r, slot_nxt;
  logic [RW-1:0]     ref_rank_r, ref_rank_nxt;
  logic              free_found_r, free_found_nxt;
  logic [FW-1:0]     free_idx_r, free_idx_nxt;
  logic [CB-1:0]     best_cnt_r, best_cnt_nxt;
  logic [RW-1:0]     best_rank_r, best_rank_nxt;
  logic [FW-1:0]     best_idx_r, best_idx_nxt;
  logic [3:0]        res_frame_r, res_frame_nxt;
  logic              res_status_r, res_status_nxt;
  logic              res_evicted_r, res_evicted_nxt;
  logic [7:0]        res_pid_r, res_pid_nxt;
  logic [3:0]        res_slot_r, res_slot_nxt;
  logic [7:0]        res_cnt_r, res_cnt_nxt;
  out_word_t         out_data_r, out_data_nxt;

  logic          ram_we;
  logic [FW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;
  logic [CB-1:0] rd_cnt;
  logic [RW-1:0] rd_rank;
  logic [7:0]    rd_pid;
  logic [3:0]    rd_slot;

  alu_ctl_t      alu_ctl;
  logic [CB-1:0] alu_cnt;
  logic [RW-1:0] alu_rank;
  logic          alu_we;
  logic          alu_better;

  logic          in_fire;
  logic [XW:0]   frame_x;
  logic          in_range;
  logic [FW-1:0] in_idx;
  logic          sweep_end;
  logic [FW-1:0] pick;
  logic          alloc_mode;
  logic [7:0]    tag_pid;
  logic [3:0]    tag_slot;

  assign in_s.ready = (state_r == S_IDLE);
  assign in_fire    = in_s.valid && in_s.ready;
  assign frame_x    = (XW + 1)'(in_s.data.frame);
  assign in_range   = frame_x < (XW + 1)'(FRAMES);
  assign in_idx     = frame_x[FW-1:0];
  assign sweep_end  = (sc_r == (FW + 1)'(FRAMES)) && !pv_r;

  assign rd_cnt  = ram_rdata[WW-1 -: CB];
  assign rd_rank = ram_rdata[RW+11 -: RW];
  assign rd_pid  = ram_rdata[11:4];
  assign rd_slot = ram_rdata[3:0];

  assign alu_ctl.mode      = mode_r;
  assign alu_ctl.is_tgt    = (pidx_r == tgt_r);
  assign alu_ctl.ent_valid = valid_r[pidx_r];

  assign alloc_mode = (mode_r == MD_ALLOC_FREE) || (mode_r == MD_ALLOC_EVICT);
  assign tag_pid    = (alloc_mode && alu_ctl.is_tgt) ? pid_r : rd_pid;
  assign tag_slot   = (alloc_mode && alu_ctl.is_tgt) ? slot_r : rd_slot;

  assign ram_waddr = pidx_r;
  assign ram_wdata = {alu_cnt, alu_rank, tag_pid, tag_slot};
  assign ram_we    = (state_r == S_UPD) && pv_r && alu_we;
  assign ram_raddr = (state_r == S_PREP) ? tgt_r : sc_r[FW-1:0];

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

  lfr_ram #(.WIDTH(WW), .DEPTH(FRAMES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lfr_alu #(.RW(RW), .CB(CB)) u_alu (
    .ctl         (alu_ctl),
    .cnt_i       (rd_cnt),
    .rank_i      (rd_rank),
    .ref_rank_i  (ref_rank_r),
    .best_cnt_i  (best_cnt_r),
    .best_rank_i (best_rank_r),
    .cnt_o       (alu_cnt),
    .rank_o      (alu_rank),
    .we_o        (alu_we),
    .better_o    (alu_better)
  );

  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    out_valid_nxt   = out_valid_r;
    sc_nxt          = sc_r;
    pv_nxt          = pv_r;
    pidx_nxt        = pidx_r;
    op_nxt          = op_r;
    mode_nxt        = mode_r;
    tgt_nxt         = tgt_r;
    pid_nxt         = pid_r;
    slot_nxt        = slot_r;
    ref_rank_nxt    = ref_rank_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    best_cnt_nxt    = best_cnt_r;
    best_rank_nxt   = best_rank_r;
    best_idx_nxt    = best_idx_r;
    res_frame_nxt   = res_frame_r;
    res_status_nxt  = res_status_r;
    res_evicted_nxt = res_evicted_r;
    res_pid_nxt     = res_pid_r;
    res_slot_nxt    = res_slot_r;
    res_cnt_nxt     = res_cnt_r;
    out_data_nxt    = out_data_r;
    pick            = free_found_r ? free_idx_r : best_idx_r;

    if (out_valid_r && out_s.ready) begin
      out_valid_nxt = 1'b0;
    end

    if ((state_r == S_SCAN) || (state_r == S_UPD)) begin
      if (sc_r < (FW + 1)'(FRAMES)) begin
        sc_nxt   = sc_r + 1'b1;
        pv_nxt   = 1'b1;
        pidx_nxt = sc_r[FW-1:0];
      end else begin
        pv_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt          = in_s.data.operation;
          pid_nxt         = in_s.data.process_id;
          slot_nxt        = slot_mod(in_s.data.virtual_slot);
          res_frame_nxt   = in_s.data.frame;
          res_status_nxt  = 1'b0;
          res_evicted_nxt = 1'b0;
          res_pid_nxt     = 8'd0;
          res_slot_nxt    = 4'd0;
          res_cnt_nxt     = 8'd0;
          sc_nxt          = '0;
          pv_nxt          = 1'b0;
          free_found_nxt  = 1'b0;
          if (in_s.data.operation == OP_ALLOC) begin
            state_nxt = S_SCAN;
          end else if (!in_range || !valid_r[in_idx]) begin
            res_status_nxt = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            tgt_nxt   = in_idx;
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        state_nxt = S_PREPD;
      end
      S_PREPD: begin
        ref_rank_nxt = rd_rank;
        case (op_r)
          OP_QUERY: begin
            res_pid_nxt  = rd_pid;
            res_slot_nxt = rd_slot;
            res_cnt_nxt  = 8'(rd_cnt);
            state_nxt    = S_DONE;
          end
          OP_ACCESS: begin
            mode_nxt  = MD_ACCESS;
            state_nxt = S_UPD;
          end
          OP_RELEASE: begin
            valid_nxt[tgt_r] = 1'b0;
            mode_nxt         = MD_RELEASE;
            state_nxt        = S_UPD;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (pv_r) begin
          if (!valid_r[pidx_r]) begin
            if (!free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = pidx_r;
            end
          end else if ((pidx_r == '0) || alu_better) begin
            best_cnt_nxt  = rd_cnt;
            best_rank_nxt = rd_rank;
            best_idx_nxt  = pidx_r;
          end
        end
        if (sweep_end) begin
          sc_nxt          = '0;
          tgt_nxt         = pick;
          valid_nxt[pick] = 1'b1;
          res_frame_nxt   = 4'(pick);
          if (free_found_r) begin
            mode_nxt = MD_ALLOC_FREE;
          end else begin
            mode_nxt        = MD_ALLOC_EVICT;
            ref_rank_nxt    = best_rank_r;
            res_evicted_nxt = 1'b1;
          end
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (pv_r && alu_ctl.is_tgt && (mode_r != MD_RELEASE)) begin
          res_pid_nxt  = tag_pid;
          res_slot_nxt = tag_slot;
          res_cnt_nxt  = 8'(alu_cnt);
        end
        if (sweep_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_s.ready) begin
          out_data_nxt.result_frame      = res_frame_r;
          out_data_nxt.status            = res_status_r;
          out_data_nxt.evicted           = res_evicted_r;
          out_data_nxt.owner_process_out = res_pid_r;
          out_data_nxt.owner_slot_out    = res_slot_r;
          out_data_nxt.use_count_out     = res_cnt_r;
          out_valid_nxt                  = 1'b1;
          state_nxt                      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      sc_r        <= '0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      sc_r        <= sc_nxt;
      pv_r        <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r        <= pidx_nxt;
    op_r          <= op_nxt;
    mode_r        <= mode_nxt;
    tgt_r         <= tgt_nxt;
    pid_r         <= pid_nxt;
    slot_r        <= slot_nxt;
    ref_rank_r    <= ref_rank_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    best_cnt_r    <= best_cnt_nxt;
    best_rank_r   <= best_rank_nxt;
    best_idx_r    <= best_idx_nxt;
    res_frame_r   <= res_frame_nxt;
    res_status_r  <= res_status_nxt;
    res_evicted_r <= res_evicted_nxt;
    res_pid_r     <= res_pid_nxt;
    res_slot_r    <= res_slot_nxt;
    res_cnt_r     <= res_cnt_nxt;
    out_data_r    <= out_data_nxt;
  end

  `LFR_ASSERT(a_we_in_update, !ram_we || (state_r == S_UPD), "RAM write outside update sweep")
  `LFR_ASSERT(a_sweep_bound, sc_r <= (FW + 1)'(FRAMES), "sweep counter past frame count")
  `LFR_ASSERT(a_evict_full, !((state_r == S_DONE) && res_evicted_r) || (&valid_r), "eviction with a free frame")
  `LFR_ASSERT(a_miss_zero, !((state_r == S_DONE) && res_status_r) || ((res_cnt_r == 8'd0) && (res_pid_r == 8'd0)), "miss word carries owner data")
  `LFR_ASSERT_NEXT(a_release_clears, (state_r == S_PREPD) && (op_r == OP_RELEASE), !valid_r[tgt_r], "released frame still valid")

endmodule

/* rtl/lfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lfr_alu.sv */
// Shared per-frame unit: count/rank update and victim compare for one entry.
// Depends on lfr_pkg.
module lfr_alu import lfr_pkg::*; #(
  parameter int RW = 4,
  parameter int CB = 8
) (
  input  alu_ctl_t        ctl,
  input  logic [CB-1:0]   cnt_i,
  input  logic [RW-1:0]   rank_i,
  input  logic [RW-1:0]   ref_rank_i,
  input  logic [CB-1:0]   best_cnt_i,
  input  logic [RW-1:0]   best_rank_i,
  output logic [CB-1:0]   cnt_o,
  output logic [RW-1:0]   rank_o,
  output logic            we_o,
  output logic            better_o
);

  logic [CB-1:0] cnt_sat;

  assign cnt_sat  = (cnt_i == {CB{1'b1}}) ? cnt_i : cnt_i + 1'b1;
  assign better_o = (cnt_i < best_cnt_i) ||
                    ((cnt_i == best_cnt_i) && (rank_i > best_rank_i));

  always_comb begin
    cnt_o  = cnt_i;
    rank_o = rank_i;
    we_o   = 1'b0;
    case (ctl.mode)
      MD_ALLOC_FREE, MD_ALLOC_EVICT: begin
        if (ctl.is_tgt) begin
          cnt_o  = CB'(1);
          rank_o = '0;
          we_o   = 1'b1;
        end else if (ctl.ent_valid) begin
          we_o = 1'b1;
          if ((ctl.mode == MD_ALLOC_FREE) || (rank_i < ref_rank_i)) begin
            rank_o = rank_i + 1'b1;
          end
        end
      end
      MD_ACCESS: begin
        if (ctl.is_tgt) begin
          cnt_o  = cnt_sat;
          rank_o = '0;
          we_o   = 1'b1;
        end else if (ctl.ent_valid && (rank_i < ref_rank_i)) begin
          rank_o = rank_i + 1'b1;
          we_o   = 1'b1;
        end
      end
      MD_RELEASE: begin
        if (!ctl.is_tgt && ctl.ent_valid && (rank_i > ref_rank_i)) begin
          rank_o = rank_i - 1'b1;
          we_o   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
